FILE: sv/bbba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbba_pkg
// Shared widths and codes of the bucketed bitmap block allocator.
// ----------------------------------------------------------------------------
package bbba_pkg;
  localparam int CAP_W  = 13;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 20;
  localparam int LEN_W  = CAP_W + CNT_W;
  localparam int SUM_W  = LEN_W + 4;
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISALIGN = 3'd3;
  localparam logic [STAT_W-1:0] ST_IS_FREE  = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
endpackage

FILE: sv/bbba_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbba_mem
// Free map memory, one row per bucket, registered read, with a valid
// bit per row so that a format takes effect at once.
// ----------------------------------------------------------------------------
module bbba_mem #(
  parameter int NUM_BUCKETS = 4,
  parameter int MAX_BLOCKS  = 64,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  rd_en_i,
  input  logic [BW-1:0]         rd_addr_i,
  output logic [MAX_BLOCKS-1:0] rd_data_o,
  output logic                  rd_vld_o,
  input  logic                  wr_en_i,
  input  logic [BW-1:0]         wr_addr_i,
  input  logic [MAX_BLOCKS-1:0] wr_data_i
);
  logic [MAX_BLOCKS-1:0]  mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] row_vld_q;
  logic [MAX_BLOCKS-1:0]  rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i] && !clr_i;
      end
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;
endmodule

FILE: sv/bbba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbba_div
// Restoring divider, one quotient bit per cycle: block offset by capacity.
// ----------------------------------------------------------------------------
module bbba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbba_pkg::ADDR_W-1:0] dividend_i,
  input  logic [bbba_pkg::CAP_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [bbba_pkg::ADDR_W-1:0] quot_o,
  output logic [bbba_pkg::CAP_W-1:0]  rem_o
);
  import bbba_pkg::*;
  localparam int CW = $clog2(ADDR_W + 1);

  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic [ADDR_W-1:0] quot_q;
  logic [CAP_W-1:0]  rem_q;
  logic [CAP_W-1:0]  dvs_q;
  logic [CAP_W:0]    trial;
  logic [CAP_W:0]    diff;

  assign trial = {rem_q, quot_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(ADDR_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q  <= diff[CAP_W-1:0];
        quot_q <= {quot_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_q  <= trial[CAP_W-1:0];
        quot_q <= {quot_q[ADDR_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

FILE: sv/bucketed_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_bitmap_block_allocator
// Segregated fit allocator: per-bucket free bitmaps held in a small memory,
// read, modified and written back by a sequencer.
//
//   channel  direction  signals
//   cfg      in         cfg_we_i, cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i, in_stall_o, func_i, request_size_i,
//                       free_address_i
//   out      out        out_valid_o, out_stall_i, status_o, block_address_o,
//                       bucket_used_o, largest_free_capacity_o
//
// An allocate sums the bucket bases, then picks, scans and writes back; a free
// uses the bit-serial divider (one quotient bit per cycle over 20 bits).
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
// Reset and every write to a capacity or count register mark all blocks free at once.
// ----------------------------------------------------------------------------
module bucketed_bitmap_block_allocator #(
  parameter int NUM_BUCKETS  = 4,
  parameter int MAX_BLOCKS   = 64,
  parameter int MAX_CAPACITY = 4096,
  localparam int CFG_IW = $clog2(2 * NUM_BUCKETS) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IW-1:0]           cfg_idx_i,
  input  logic [bbba_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bbba_pkg::CAP_W-1:0]  request_size_i,
  input  logic [bbba_pkg::ADDR_W-1:0] free_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bbba_pkg::STAT_W-1:0] status_o,
  output logic [bbba_pkg::ADDR_W-1:0] block_address_o,
  output logic [1:0]                  bucket_used_o,
  output logic [bbba_pkg::CAP_W-1:0]  largest_free_capacity_o
);
  import bbba_pkg::*;

  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BASE = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_AWR  = 4'd4;
  localparam logic [3:0] S_ASUM = 4'd5;
  localparam logic [3:0] S_HOLD = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_FCHK = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_q, state_d;

  logic [CAP_W-1:0]  cap_q  [NUM_BUCKETS];
  logic [CNT_W-1:0]  cnt_q  [NUM_BUCKETS];
  logic [CNT_W-1:0]  fc_q   [NUM_BUCKETS];
  logic [SUM_W-1:0]  base_q [NUM_BUCKETS];
  logic [LEN_W-1:0]  len_q  [NUM_BUCKETS];
  logic [SUM_W-1:0]  acc_q;
  logic [BW-1:0]     bsel_q;
  logic [BW-1:0]     sel_q;
  logic              func_q;
  logic [CAP_W-1:0]  size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [STAT_W-1:0] status_q;
  logic [SUM_W-1:0]  baddr_q;
  logic [IDX_W-1:0]  idx_q;
  logic [MAX_BLOCKS-1:0] map_q;
  logic [LEN_W-1:0]  prod_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [1:0]        out_bucket_q;
  logic [CAP_W-1:0]  out_largest_q;

  logic              accept;
  logic              fin_load;
  logic              cfg_cap_wr;
  logic              cfg_cnt_wr;
  logic [CAP_W-1:0]  cap_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [BW-1:0]     cfg_sel;

  logic              pick_found;
  logic [BW-1:0]     pick;
  logic              hold_found;
  logic [BW-1:0]     hold;
  logic [CAP_W-1:0]  largest;
  logic [LEN_W-1:0]  len_cur;
  logic [MAX_BLOCKS-1:0] sel_mask;
  logic [MAX_BLOCKS-1:0] rd_map;
  logic [IDX_W-1:0]  ffs;
  logic [SUM_W-1:0]  off_full;

  logic                  mem_rd_en;
  logic [BW-1:0]         mem_rd_addr;
  logic [MAX_BLOCKS-1:0] mem_rd_data;
  logic                  mem_rd_vld;
  logic                  mem_wr_en;
  logic [MAX_BLOCKS-1:0] mem_wr_data;

  logic              div_start;
  logic              div_busy;
  logic [ADDR_W-1:0] div_quot;
  logic [CAP_W-1:0]  div_rem;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign fin_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign cfg_cap_wr = cfg_we_i && (cfg_idx_i < CFG_IW'(NUM_BUCKETS));
  assign cfg_cnt_wr = cfg_we_i && !cfg_cap_wr && (cfg_idx_i < CFG_IW'(2 * NUM_BUCKETS));
  assign cfg_sel    = cfg_cap_wr ? BW'(cfg_idx_i) : BW'(cfg_idx_i - CFG_IW'(NUM_BUCKETS));

  always_comb begin
    cap_new = cfg_wdata_i;
    if (cap_new == '0) begin
      cap_new = CAP_W'(1);
    end
    if ({4'b0, cap_new} > 17'(MAX_CAPACITY)) begin
      cap_new = CAP_W'(MAX_CAPACITY);
    end
    cnt_new = cfg_wdata_i[CNT_W-1:0];
    if (cnt_new > CNT_W'(MAX_BLOCKS)) begin
      cnt_new = CNT_W'(MAX_BLOCKS);
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick       = '0;
    hold_found = 1'b0;
    hold       = '0;
    largest    = '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      if (fc_q[b] != '0 && cap_q[b] >= size_q) begin
        if (!pick_found || cap_q[b] < cap_q[pick]) begin
          pick = BW'(b);
        end
        pick_found = 1'b1;
      end
      if (!hold_found && {4'b0, addr_q} >= base_q[b] &&
          {4'b0, addr_q} < base_q[b] + SUM_W'(len_q[b])) begin
        hold_found = 1'b1;
        hold       = BW'(b);
      end
      if (fc_q[b] != '0 && cap_q[b] > largest) begin
        largest = cap_q[b];
      end
    end
  end

  assign len_cur = LEN_W'(cap_q[bsel_q]) * LEN_W'(cnt_q[bsel_q]);

  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      sel_mask[j] = (CNT_W'(j) < cnt_q[sel_q]);
    end
    rd_map = (mem_rd_vld ? mem_rd_data : sel_mask) & sel_mask;
    ffs = IDX_W'(MAX_BLOCKS - 1);
    for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
      if (rd_map[j]) begin
        ffs = IDX_W'(j);
      end
    end
  end

  assign off_full = {4'b0, addr_q} - base_q[hold];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_BASE;
      S_BASE: begin
        if (bsel_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = (func_q == FUNC_FREE) ? S_HOLD : S_PICK;
        end
      end
      S_PICK: state_d = pick_found ? S_SCAN : S_FIN;
      S_SCAN: state_d = S_AWR;
      S_AWR:  state_d = S_ASUM;
      S_ASUM: state_d = S_FIN;
      S_HOLD: state_d = hold_found ? S_DIV : S_FIN;
      S_DIV:  if (!div_busy) state_d = S_FRD;
      S_FRD:  state_d = S_FCHK;
      S_FCHK: state_d = S_FIN;
      S_FIN:  if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign mem_rd_en   = (state_q == S_PICK && pick_found) || (state_q == S_FRD);
  assign mem_rd_addr = (state_q == S_PICK) ? pick : sel_q;
  assign div_start   = (state_q == S_HOLD) && hold_found;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_data = map_q;
    if (state_q == S_AWR) begin
      mem_wr_en = 1'b1;
    end else if (state_q == S_FCHK && status_q == ST_OK && div_rem == '0 &&
                 div_quot[ADDR_W-1:IDX_W] == '0 && !rd_map[div_quot[IDX_W-1:0]]) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = rd_map | (MAX_BLOCKS'(1) << div_quot[IDX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        cap_q[b] <= CAP_W'(1);
        cnt_q[b] <= '0;
        fc_q[b]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_cap_wr) begin
        cap_q[cfg_sel] <= cap_new;
      end
      if (cfg_cnt_wr) begin
        cnt_q[cfg_sel] <= cnt_new;
      end
      if (cfg_cap_wr || cfg_cnt_wr) begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
          fc_q[b] <= (cfg_cnt_wr && cfg_sel == BW'(b)) ? cnt_new : cnt_q[b];
        end
      end else if (state_q == S_AWR) begin
        fc_q[sel_q] <= fc_q[sel_q] - 1'b1;
      end else if (mem_wr_en && state_q == S_FCHK) begin
        fc_q[sel_q] <= fc_q[sel_q] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        func_q   <= func_i;
        size_q   <= request_size_i;
        addr_q   <= free_address_i;
        acc_q    <= '0;
        bsel_q   <= '0;
        status_q <= ST_OK;
        baddr_q  <= '0;
        sel_q    <= '0;
      end
      S_BASE: begin
        base_q[bsel_q] <= acc_q;
        len_q[bsel_q]  <= len_cur;
        acc_q          <= acc_q + SUM_W'(len_cur);
        bsel_q         <= bsel_q + 1'b1;
      end
      S_PICK: begin
        if (pick_found) begin
          sel_q <= pick;
        end else begin
          status_q <= ST_NO_SPACE;
        end
      end
      S_SCAN: begin
        idx_q <= ffs;
        map_q <= rd_map & ~(MAX_BLOCKS'(1) << ffs);
      end
      S_AWR:  prod_q <= LEN_W'(idx_q) * LEN_W'(cap_q[sel_q]);
      S_ASUM: baddr_q <= base_q[sel_q] + SUM_W'(prod_q);
      S_HOLD: begin
        if (hold_found) begin
          sel_q <= hold;
        end else begin
          status_q <= ST_RANGE;
        end
      end
      S_FCHK: begin
        if (div_rem != '0) begin
          status_q <= ST_MISALIGN;
        end else if (!mem_wr_en) begin
          status_q <= ST_IS_FREE;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          out_status_q  <= status_q;
          out_addr_q    <= baddr_q[ADDR_W-1:0];
          out_bucket_q  <= 2'(sel_q);
          out_largest_q <= largest;
        end
      end
      default: ;
    endcase
  end

  bbba_mem #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_cap_wr || cfg_cnt_wr),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .rd_vld_o  (mem_rd_vld),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (sel_q),
    .wr_data_i (mem_wr_data)
  );

  bbba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_full[ADDR_W-1:0]),
    .divisor_i  (cap_q[hold]),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o             = out_valid_q;
  assign status_o                = out_status_q;
  assign block_address_o         = out_addr_q;
  assign bucket_used_o           = out_bucket_q;
  assign largest_free_capacity_o = out_largest_q;
endmodule

FILE: tb/sv/bbba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbba_checker
// Watches the register port and both request channels of the bucketed bitmap
// block allocator. It keeps its own copy of the bucket settings and free
// bitmaps, works out the reply for every accepted request and compares each
// accepted reply with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module bbba_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_idx_i,
  input  logic [bbba_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        func_i,
  input  logic [bbba_pkg::CAP_W-1:0]  request_size_i,
  input  logic [bbba_pkg::ADDR_W-1:0] free_address_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [bbba_pkg::STAT_W-1:0] status_i,
  input  logic [bbba_pkg::ADDR_W-1:0] block_address_i,
  input  logic [1:0]                  bucket_used_i,
  input  logic [bbba_pkg::CAP_W-1:0]  largest_free_capacity_i,
  output int                          errors_o,
  output int                          pending_o
);
  import bbba_pkg::*;

  localparam int NB = 4;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        bucket_used;
    logic [CAP_W-1:0]  largest_free_capacity;
  } reply_t;

  reply_t      reply_q[$];
  int unsigned cap_r[NB];
  int unsigned cnt_r[NB];
  logic [63:0] fmap[NB];
  int unsigned fcnt[NB];

  assign pending_o = reply_q.size();

  function automatic logic [63:0] block_mask(int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void reformat();
    for (int b = 0; b < NB; b++) begin
      fmap[b] = block_mask(cnt_r[b]);
      fcnt[b] = cnt_r[b];
    end
  endfunction

  function automatic void settings_reset();
    for (int b = 0; b < NB; b++) begin
      cap_r[b] = 1;
      cnt_r[b] = 0;
    end
    reformat();
  endfunction

  function automatic void apply_write(logic [3:0] idx, logic [CAP_W-1:0] wdata);
    int unsigned v;
    if (idx < NB) begin
      v = wdata;
      if (v < 1) v = 1;
      if (v > 4096) v = 4096;
      cap_r[idx] = v;
      reformat();
    end else if (idx < 2 * NB) begin
      v = wdata[6:0];
      if (v > 64) v = 64;
      cnt_r[idx-NB] = v;
      reformat();
    end
  endfunction

  function automatic reply_t serve_request(logic fn, logic [CAP_W-1:0] size,
                                           logic [ADDR_W-1:0] addr);
    reply_t      r;
    longint      base[NB];
    longint      pool_end;
    longint      len;
    longint      off;
    longint      idx;
    longint      best;
    int          pick;
    int          hold;
    int unsigned i;
    logic [63:0] m;
    r = '0;
    pool_end = 0;
    for (int b = 0; b < NB; b++) begin
      base[b] = pool_end;
      pool_end += longint'(cap_r[b]) * cnt_r[b];
    end
    if (fn == FUNC_ALLOC) begin
      pick = -1;
      for (int b = 0; b < NB; b++) begin
        if (fcnt[b] == 0 || cap_r[b] < size) continue;
        if (pick < 0 || cap_r[b] < cap_r[pick]) pick = b;
      end
      if (pick < 0) begin
        r.status = ST_NO_SPACE;
      end else begin
        m = fmap[pick] & block_mask(cnt_r[pick]);
        i = 0;
        while (i < 63 && !m[i]) i++;
        fmap[pick][i] = 1'b0;
        fcnt[pick]--;
        r.status = ST_OK;
        r.block_address = ADDR_W'(base[pick] + longint'(i) * cap_r[pick]);
        r.bucket_used = 2'(pick);
      end
    end else begin
      hold = -1;
      for (int b = 0; b < NB; b++) begin
        len = longint'(cap_r[b]) * cnt_r[b];
        if (addr >= base[b] && addr < base[b] + len) begin
          hold = b;
          break;
        end
      end
      if (hold < 0) begin
        r.status = ST_RANGE;
      end else begin
        off = addr - base[hold];
        idx = off / cap_r[hold];
        r.bucket_used = 2'(hold);
        if (off % cap_r[hold] != 0) r.status = ST_MISALIGN;
        else if (idx >= 64 || fmap[hold][idx]) r.status = ST_IS_FREE;
        else begin
          fmap[hold][idx] = 1'b1;
          fcnt[hold]++;
          r.status = ST_OK;
        end
      end
    end
    best = 0;
    for (int b = 0; b < NB; b++)
      if (fcnt[b] != 0 && cap_r[b] > best) best = cap_r[b];
    r.largest_free_capacity = CAP_W'(best);
    return r;
  endfunction

  initial begin
    errors_o = 0;
    settings_reset();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      settings_reset();
      reply_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $error("reply with no request outstanding");
          errors_o++;
        end else begin
          want = reply_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            errors_o++;
          end
          if (block_address_i !== want.block_address) begin
            $error("block_address: expected %0d, actual %0d",
                   want.block_address, block_address_i);
            errors_o++;
          end
          if (bucket_used_i !== want.bucket_used) begin
            $error("bucket_used: expected %0d, actual %0d",
                   want.bucket_used, bucket_used_i);
            errors_o++;
          end
          if (largest_free_capacity_i !== want.largest_free_capacity) begin
            $error("largest_free_capacity: expected %0d, actual %0d",
                   want.largest_free_capacity, largest_free_capacity_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        reply_q.push_back(serve_request(func_i, request_size_i, free_address_i));
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_wdata_i);
    end
  end
endmodule

FILE: tb/sv/bucketed_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_bitmap_block_allocator_tb
// Drives allocate and free requests through the allocator under a series of
// bucket settings, with bursty requests and a stalling reply side. A checker
// beside the block predicts and compares every reply; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module bucketed_bitmap_block_allocator_tb;
  import bbba_pkg::*;

  localparam int NB        = 4;
  localparam int LIMIT     = 1000000;
  localparam int DRAIN_CYC = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_idx = '0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = FUNC_ALLOC;
  logic [CAP_W-1:0]   request_size = '0;
  logic [ADDR_W-1:0]  free_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  block_address;
  logic [1:0]         bucket_used;
  logic [CAP_W-1:0]   largest_free_capacity;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  int unsigned        eff_cap[NB];
  int unsigned        eff_cnt[NB];
  int                 burst_left = 0;
  int                 stall_mode = 0;
  int                 stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bucketed_bitmap_block_allocator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .request_size_i(request_size), .free_address_i(free_address),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .block_address_o(block_address), .bucket_used_o(bucket_used),
    .largest_free_capacity_o(largest_free_capacity)
  );

  bbba_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .func_i(func),
    .request_size_i(request_size), .free_address_i(free_address),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .status_i(status),
    .block_address_i(block_address), .bucket_used_i(bucket_used),
    .largest_free_capacity_i(largest_free_capacity),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("bucketed_bitmap_block_allocator: mismatch");
      $finish;
    end
  end

  // reply side: runs of no stall, heavy stall and random stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(int idx, int unsigned value);
    int unsigned v;
    cfg_we <= 1'b1;
    cfg_idx <= 4'(idx);
    cfg_wdata <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    v = CAP_W'(value);
    if (idx < NB) begin
      eff_cap[idx] = (v < 1) ? 1 : (v > 4096) ? 4096 : v;
    end else if (idx < 2 * NB) begin
      v = v & 32'h7f;
      eff_cnt[idx-NB] = (v > 64) ? 64 : v;
    end
  endtask

  task automatic send(logic fn, int unsigned size, int unsigned addr);
    int gap;
    in_valid <= 1'b1;
    func <= fn;
    request_size <= CAP_W'(size);
    free_address <= ADDR_W'(addr);
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic hold_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned bucket_base(int bk);
    int unsigned s;
    s = 0;
    for (int b = 0; b < bk; b++) s += eff_cap[b] * eff_cnt[b];
    return s;
  endfunction

  task automatic random_request();
    int          bk;
    int unsigned size;
    int unsigned addr;
    int unsigned fin;
    bk = $urandom_range(0, NB - 1);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0: size = 0;
        1: size = 4096;
        2: size = 13'h1fff;
        3: size = $urandom_range(0, 8191);
        4, 5: size = eff_cap[bk];
        6: size = eff_cap[bk] + 1;
        7: size = eff_cap[bk] - 1;
        default: size = $urandom_range(0, 64);
      endcase
      send(FUNC_ALLOC, size, $urandom_range(0, 20'hfffff));
    end else begin
      fin = bucket_base(NB);
      case ($urandom_range(0, 9))
        0: addr = $urandom_range(0, 20'hfffff);
        1: addr = fin + $urandom_range(0, 3);
        2: addr = bucket_base(bk) + $urandom_range(0, 7) * eff_cap[bk] + 1;
        default: begin
          if (eff_cnt[bk] == 0) addr = bucket_base(bk);
          else addr = bucket_base(bk) + $urandom_range(0, eff_cnt[bk] - 1) * eff_cap[bk];
        end
      endcase
      send(FUNC_FREE, $urandom_range(0, 8191), addr);
    end
  endtask

  task automatic random_settings();
    for (int b = 0; b < NB; b++) begin
      case ($urandom_range(0, 5))
        0: write_reg(b, 1);
        1: write_reg(b, 4096);
        2: write_reg(b, 0);
        3: write_reg(b, $urandom_range(0, 8191));
        4: write_reg(b, $urandom_range(1, 64));
        default: write_reg(b, $urandom_range(1, 16));
      endcase
    end
    for (int b = 0; b < NB; b++) begin
      case ($urandom_range(0, 7))
        0: write_reg(NB + b, 0);
        1: write_reg(NB + b, 64);
        2: write_reg(NB + b, ($urandom_range(0, 63) << 7) | $urandom_range(65, 127));
        3: write_reg(NB + b, $urandom_range(0, 8191));
        default: write_reg(NB + b, $urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    for (int b = 0; b < NB; b++) begin
      eff_cap[b] = 1;
      eff_cnt[b] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings from reset: nothing can be served
    send(FUNC_ALLOC, 0, 0);
    send(FUNC_FREE, 0, 0);
    hold_idle();
    wait_drained();

    write_reg(0, 4096);
    write_reg(1, 16);
    write_reg(2, 16);
    write_reg(3, 0);
    write_reg(4, 2);
    write_reg(5, 3);
    write_reg(6, 127);
    write_reg(7, 1);
    write_reg(8, 13'h1fff);
    write_reg(15, 5);
    send(FUNC_ALLOC, 0, 20'hfffff);
    send(FUNC_ALLOC, 0, 0);
    send(FUNC_ALLOC, 16, 0);
    send(FUNC_ALLOC, 17, 0);
    send(FUNC_ALLOC, 4096, 0);
    send(FUNC_ALLOC, 4096, 0);
    send(FUNC_ALLOC, 4096, 0);
    send(FUNC_ALLOC, 13'h1fff, 0);
    send(FUNC_FREE, 0, 0);
    send(FUNC_FREE, 0, 0);
    send(FUNC_FREE, 1, 1);
    send(FUNC_FREE, 0, 8192);
    send(FUNC_FREE, 0, 8192 + 16);
    send(FUNC_FREE, 0, 8192 + 17);
    send(FUNC_FREE, 0, 8192 + 48 + 1024 + 1);
    send(FUNC_FREE, 0, 20'hfffff);
    send(FUNC_FREE, 13'h1fff, 8192 + 48 + 1024);
    send(FUNC_ALLOC, 1, 0);
    hold_idle();
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      random_settings();
      for (int n = 0; n < 100; n++) begin
        if (n == 50 && ph[0]) begin
          hold_idle();
          wait_drained();
        end
        random_request();
      end
      hold_idle();
      wait_drained();
    end

    if (errors == 0) $display("bucketed_bitmap_block_allocator: match");
    else $display("bucketed_bitmap_block_allocator: mismatch");
    $finish;
  end
endmodule
